### rtl/rk4ed_pkg.sv
// rk4ed_pkg: shared constants, types and micro-op table for the rk4 decay integrator
// no dependencies; imported by every module of the block

package rk4ed_pkg;

    // number format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 28;
    localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // configuration
    localparam int STEP_W    = 29;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 29;
    localparam logic [STEP_W-1:0]  STEP_SIZE_RST  = STEP_W'(2684355);
    localparam logic [COUNT_W-1:0] STEP_COUNT_RST = COUNT_W'(100);

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLING   = CFG_IDX_W'(2);

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MAG_W  = PROD_W - FRAC_BITS + 1;
    // x/3 = (x * RECIP3) >> 32, exact for x below 2^30
    localparam logic [MUL_W-1:0] RECIP3 = 32'h5555_5556;
    localparam int RECIP3_SHIFT = 32;
    // x/15 = (x * RECIP15) >> 35, exact for any 32-bit x
    localparam logic [MUL_W-1:0] RECIP15 = 32'h8888_8889;
    localparam int RECIP15_SHIFT = 35;
    localparam int QUOT_W = PROD_W - RECIP15_SHIFT;

    // stream words
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    // sequencer
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(10);
    localparam int CIDX_W = 3;
    localparam logic [CIDX_W-1:0] CIDX_LAST = CIDX_W'(4);

    typedef enum logic {
        K_Y0,
        K_T
    } ksrc_t;

    typedef enum logic [1:0] {
        C_SIX,
        C_THIRD,
        C_HALF,
        C_ONE
    } coef_sel_t;

    typedef enum logic [1:0] {
        ADD_Y_Y0,
        ADD_T_Y0,
        ADD_Y_Y
    } add_op_t;

    typedef struct packed {
        logic      issue;
        ksrc_t     ksrc;
        coef_sel_t coef;
        add_op_t   add;
    } uop_t;

    typedef struct packed {
        logic start;
        logic take;
    } core_ctl_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_sts_t;

    // one rk4 step as 11 phases; a product issued in one phase is added in the next
    function automatic uop_t uop_at(input logic [PHASE_W-1:0] phase);
        uop_t u;
        u = '{issue: 1'b0, ksrc: K_Y0, coef: C_SIX, add: ADD_Y_Y0};
        unique case (phase)
            PHASE_W'(0): u = '{issue: 1'b1, ksrc: K_Y0, coef: C_SIX,   add: ADD_Y_Y0};
            PHASE_W'(1): u = '{issue: 1'b1, ksrc: K_Y0, coef: C_HALF,  add: ADD_T_Y0};
            PHASE_W'(3): u = '{issue: 1'b1, ksrc: K_T,  coef: C_THIRD, add: ADD_Y_Y};
            PHASE_W'(4): u = '{issue: 1'b1, ksrc: K_T,  coef: C_HALF,  add: ADD_T_Y0};
            PHASE_W'(6): u = '{issue: 1'b1, ksrc: K_T,  coef: C_THIRD, add: ADD_Y_Y};
            PHASE_W'(7): u = '{issue: 1'b1, ksrc: K_T,  coef: C_ONE,   add: ADD_T_Y0};
            PHASE_W'(9): u = '{issue: 1'b1, ksrc: K_T,  coef: C_SIX,   add: ADD_Y_Y};
            default:     u = '{issue: 1'b0, ksrc: K_Y0, coef: C_SIX,   add: ADD_Y_Y0};
        endcase
        return u;
    endfunction

    // rounding of 8*r/30 for a remainder r of a division by 15
    function automatic logic [2:0] err_round(input logic [3:0] r);
        logic [2:0] v;
        case (r) inside
            4'd2, 4'd3, 4'd4, 4'd5:   v = 3'd1;
            4'd6, 4'd7, 4'd8, 4'd9:   v = 3'd2;
            4'd10, 4'd11, 4'd12, 4'd13: v = 3'd3;
            4'd14:                    v = 3'd4;
            default:                  v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/rk4_exponential_decay_integrator.sv
// rk4_exponential_decay_integrator: top level with stream ports, config registers
// and output register; depends on rk4ed_pkg and rk4ed_core

// Integrates y' = -y from each initial value (signed Q3.28) over step_count
// classic RK4 steps of size step_size (unsigned Q1.28) and returns the final
// value; with doubling_mode set every step is a full step plus two half steps,
// the half-step result is kept and the word also carries 4*(half-full)/15 of
// the last step (zero otherwise). All arithmetic saturates. One value is worked
// on at a time: after an accepted word the block first derives the step
// coefficients, then runs each RK4 step on its single shared 32x32 multiplier
// (four dependent stages, seven products), and in doubling mode it then forms
// the error estimate. The result sits in an output register, so a new value
// may start while the previous result waits. Config writes belong to idle
// periods only.

module rk4_exponential_decay_integrator
    import rk4ed_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]     cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] initial_value
    input  logic                  s_tlast,   // batch_end
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] final_value, [63:32] error_estimate
    output logic                  m_tlast    // batch_end_out
);

    logic [STEP_W-1:0]     step_size_reg;
    logic [COUNT_W-1:0]    step_count_reg;
    logic                  doubling_reg;
    logic                  batch_end_reg;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    core_ctl_t             ctl;
    core_sts_t             sts;
    logic [DATA_WIDTH-1:0] final_value;
    logic [DATA_WIDTH-1:0] error_estimate;
    logic                  out_free;

    // register writes, no read-back; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg  <= STEP_SIZE_RST;
            step_count_reg <= STEP_COUNT_RST;
            doubling_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STEP_SIZE:  step_size_reg  <= cfg_wdata[STEP_W-1:0];
                REG_STEP_COUNT: step_count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_DOUBLING:   doubling_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input side: ready whenever the sequencer is idle
    assign s_tready  = sts.idle;
    assign ctl.start = s_tvalid && sts.idle;

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            batch_end_reg <= s_tlast;
        end
    end

    rk4ed_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .step_size      (step_size_reg),
        .step_count     (step_count_reg),
        .doubling_mode  (doubling_reg),
        .init_value     (s_tdata[DATA_WIDTH-1:0]),
        .sts            (sts),
        .final_value    (final_value),
        .error_estimate (error_estimate)
    );

    // output register: loads a finished result once the previous word is gone
    assign out_free = !m_tvalid_reg || m_tready;
    assign ctl.take = sts.res_valid && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            m_tdata_reg <= {error_estimate, final_value};
            m_tlast_reg <= batch_end_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/rk4ed_mul.sv
// rk4ed_mul: the shared unsigned multiplier with a registered product
// depends on rk4ed_pkg

module rk4ed_mul
    import rk4ed_pkg::*;
(
    input  logic              aclk,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### rtl/rk4ed_core.sv
// rk4ed_core: sequencer and datapath around the shared multiplier
// depends on rk4ed_pkg and rk4ed_mul

module rk4ed_core
    import rk4ed_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  core_ctl_t             ctl,
    input  logic [STEP_W-1:0]     step_size,
    input  logic [COUNT_W-1:0]    step_count,
    input  logic                  doubling_mode,
    input  logic [DATA_WIDTH-1:0] init_value,
    output core_sts_t             sts,
    output logic [DATA_WIDTH-1:0] final_value,
    output logic [DATA_WIDTH-1:0] error_estimate
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_STEP,
        S_EDIFF,
        S_EMUL,
        S_EFIN,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [PHASE_W-1:0]    phase_reg;
    logic [CIDX_W-1:0]     cidx_reg;
    logic [1:0]            sub_reg;
    logic [COUNT_W-1:0]    step_cnt_reg;
    logic                  a_valid_reg;
    add_op_t               a_op_reg;
    logic                  a_neg_reg;

    logic [DATA_WIDTH-1:0] y0_reg;
    logic [DATA_WIDTH-1:0] yf_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic [DATA_WIDTH-1:0] t_reg;
    logic [DATA_WIDTH-1:0] err_reg;
    logic [MUL_W-1:0]      d_reg;
    logic                  eneg_reg;
    logic [STEP_W-1:0]     c6f_reg;
    logic [STEP_W-1:0]     c3f_reg;
    logic [STEP_W-1:0]     c6h_reg;
    logic [STEP_W-1:0]     c3h_reg;

    logic [MUL_W-1:0]      op_a;
    logic [MUL_W-1:0]      op_b;
    logic [PROD_W-1:0]     prod;

    uop_t                  uop;
    logic                  half_sel;
    logic [STEP_W-1:0]     h_step;
    logic [STEP_W-1:0]     coef;
    logic [STEP_W:0]       num;
    logic [DATA_WIDTH-1:0] k_src;
    logic                  k_neg;
    logic [DATA_WIDTH-1:0] k_mag;

    logic [MAG_W-1:0]      p_mag;
    logic [DATA_WIDTH-1:0] p_val;
    logic [DATA_WIDTH-1:0] add_base;
    logic [DATA_WIDTH:0]   sum_ext;
    logic [DATA_WIDTH-1:0] sum;

    logic [DATA_WIDTH:0]   diff;
    logic [QUOT_W-1:0]     quot;
    logic [3:0]            rem;
    logic [DATA_WIDTH-1:0] err_mag;
    logic [DATA_WIDTH-1:0] err_val;
    logic                  last_step;

    rk4ed_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // coefficient selection
    assign uop      = uop_at(phase_reg);
    assign half_sel = doubling_mode && (sub_reg != 2'd0);
    assign h_step   = STEP_W'(({1'b0, step_size} + (STEP_W+1)'(1)) >> 1);

    always_comb begin
        case (uop.coef)
            C_SIX:   coef = half_sel ? c6h_reg : c6f_reg;
            C_THIRD: coef = half_sel ? c3h_reg : c3f_reg;
            C_HALF:  coef = half_sel ? STEP_W'(({1'b0, h_step} + (STEP_W+1)'(1)) >> 1)
                                     : h_step;
            default: coef = half_sel ? h_step : step_size;
        endcase
    end

    // numerators that go through the divide-by-three reciprocal
    always_comb begin
        case (cidx_reg)
            CIDX_W'(0): num = ({1'b0, step_size} + (STEP_W+1)'(3)) >> 1;
            CIDX_W'(1): num = {1'b0, step_size} + (STEP_W+1)'(1);
            CIDX_W'(2): num = ({1'b0, h_step} + (STEP_W+1)'(3)) >> 1;
            default:    num = {1'b0, h_step} + (STEP_W+1)'(1);
        endcase
    end

    // k = -src, saturated; split into sign and magnitude for the multiplier
    assign k_src = (uop.ksrc == K_T) ? t_reg : y0_reg;
    assign k_neg = !k_src[DATA_WIDTH-1] && (k_src != '0);
    always_comb begin
        if (k_src == VMIN) begin
            k_mag = VMAX;
        end else if (k_src[DATA_WIDTH-1]) begin
            k_mag = -k_src;
        end else begin
            k_mag = k_src;
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_COEF: begin
                op_a = MUL_W'(num);
                op_b = RECIP3;
            end
            S_STEP: begin
                op_a = MUL_W'(k_mag);
                op_b = MUL_W'(coef);
            end
            S_EMUL: begin
                op_a = d_reg;
                op_b = RECIP15;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // round half away, drop the fraction, saturate, then saturating add
    assign p_mag = MAG_W'(prod[PROD_W-1:FRAC_BITS]) + MAG_W'(prod[FRAC_BITS-1]);

    always_comb begin
        if (a_neg_reg) begin
            if (p_mag > MAG_W'(VMAX) + MAG_W'(1)) begin
                p_val = VMIN;
            end else begin
                p_val = -p_mag[DATA_WIDTH-1:0];
            end
        end else begin
            if (p_mag > MAG_W'(VMAX)) begin
                p_val = VMAX;
            end else begin
                p_val = p_mag[DATA_WIDTH-1:0];
            end
        end
    end

    assign add_base = (a_op_reg == ADD_Y_Y) ? y_reg : y0_reg;
    assign sum_ext  = {add_base[DATA_WIDTH-1], add_base} + {p_val[DATA_WIDTH-1], p_val};

    always_comb begin
        if (sum_ext[DATA_WIDTH] != sum_ext[DATA_WIDTH-1]) begin
            sum = sum_ext[DATA_WIDTH] ? VMIN : VMAX;
        end else begin
            sum = sum_ext[DATA_WIDTH-1:0];
        end
    end

    // error estimate: 4*q + round(8*r/30), r = d - 15*q taken mod 16
    assign diff    = {y0_reg[DATA_WIDTH-1], y0_reg} - {yf_reg[DATA_WIDTH-1], yf_reg};
    assign quot    = prod[PROD_W-1:RECIP15_SHIFT];
    assign rem     = d_reg[3:0] + quot[3:0];
    assign err_mag = DATA_WIDTH'({quot, 2'b00}) + DATA_WIDTH'(err_round(rem));
    assign err_val = eneg_reg ? -err_mag : err_mag;

    assign last_step = ({1'b0, step_cnt_reg} + (COUNT_W+1)'(1)) == {1'b0, step_count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= '0;
            cidx_reg     <= '0;
            sub_reg      <= '0;
            step_cnt_reg <= '0;
            a_valid_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (ctl.start) begin
                        y0_reg       <= init_value;
                        err_reg      <= '0;
                        phase_reg    <= '0;
                        cidx_reg     <= '0;
                        sub_reg      <= '0;
                        step_cnt_reg <= '0;
                        a_valid_reg  <= 1'b0;
                        state_reg    <= (step_count == '0) ? S_DONE : S_COEF;
                    end
                end
                S_COEF: begin
                    cidx_reg <= cidx_reg + CIDX_W'(1);
                    case (cidx_reg)
                        CIDX_W'(1): c6f_reg <= prod[RECIP3_SHIFT +: STEP_W];
                        CIDX_W'(2): c3f_reg <= prod[RECIP3_SHIFT +: STEP_W];
                        CIDX_W'(3): c6h_reg <= prod[RECIP3_SHIFT +: STEP_W];
                        CIDX_W'(4): c3h_reg <= prod[RECIP3_SHIFT +: STEP_W];
                        default: ;
                    endcase
                    if (cidx_reg == CIDX_LAST) begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP: begin
                    a_valid_reg <= uop.issue;
                    a_op_reg    <= uop.add;
                    a_neg_reg   <= k_neg;
                    if (a_valid_reg) begin
                        if (a_op_reg == ADD_T_Y0) begin
                            t_reg <= sum;
                        end else begin
                            y_reg <= sum;
                        end
                    end
                    if (phase_reg == PHASE_LAST) begin
                        phase_reg <= '0;
                        if (doubling_mode && sub_reg == 2'd0) begin
                            yf_reg  <= sum;
                            sub_reg <= 2'd1;
                        end else if (doubling_mode && sub_reg == 2'd1) begin
                            y0_reg  <= sum;
                            sub_reg <= 2'd2;
                        end else begin
                            y0_reg  <= sum;
                            sub_reg <= 2'd0;
                            if (last_step) begin
                                state_reg <= doubling_mode ? S_EDIFF : S_DONE;
                            end else begin
                                step_cnt_reg <= step_cnt_reg + COUNT_W'(1);
                            end
                        end
                    end else begin
                        phase_reg <= phase_reg + PHASE_W'(1);
                    end
                end
                S_EDIFF: begin
                    eneg_reg  <= diff[DATA_WIDTH];
                    d_reg     <= diff[DATA_WIDTH] ? MUL_W'(-diff) : MUL_W'(diff);
                    state_reg <= S_EMUL;
                end
                S_EMUL: begin
                    state_reg <= S_EFIN;
                end
                S_EFIN: begin
                    err_reg   <= err_val;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (ctl.take) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sts.idle        = (state_reg == S_IDLE);
    assign sts.res_valid   = (state_reg == S_DONE);
    assign final_value     = y0_reg;
    assign error_estimate  = err_reg;

endmodule

### rtl/rk4ed_chk.sv
// rk4ed_chk: port-level checks for the rk4 decay integrator, bound to the top
// depends on rk4ed_pkg

module rk4ed_chk
    import rk4ed_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    // one value at a time: an accepted word closes the input side
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after accepting a word");

    // a stalled result word holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // no new result appears in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after accept");

endmodule

bind rk4_exponential_decay_integrator rk4ed_chk u_rk4ed_chk (.*);

### tb/tb.sv
// tb: self-checking testbench for rk4_exponential_decay_integrator
// needs rk4ed_pkg and the rtl of the block; predicts every result word in-line
// and compares it field by field through directed, long-run and random phases

module tb;
    import rk4ed_pkg::*;

    typedef logic signed [DATA_WIDTH-1:0] fx_t;

    // one expected result word
    typedef struct packed {
        fx_t  final_value;
        fx_t  error_estimate;
        logic batch_end;
    } decay_result_t;

    // coefficients of one step size, all in unsigned Q1.FRAC_BITS
    typedef struct {
        logic [63:0] c6;
        logic [63:0] c3;
        logic [63:0] c2;
        logic [63:0] c1;
    } rk_coef_t;

    localparam longint FX_HI = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint FX_LO = -FX_HI - 1;
    localparam logic [63:0] MAG_TOP = 64'd1 << (DATA_WIDTH - 1);
    localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
    localparam logic [63:0] STEP_TOP = (64'd1 << STEP_W) - 1;

    // clock, reset and every block input start at known values
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_STEP_SIZE;
    logic [CFG_DW-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // [31:0] initial_value
    logic                  s_tlast = 1'b0; // batch_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // [31:0] final_value, [63:32] error_estimate
    logic                  m_tlast;        // batch_end_out

    // predictor's own copy of the registers
    logic [STEP_W-1:0]  cfg_step = STEP_SIZE_RST;
    logic [COUNT_W-1:0] cfg_count = STEP_COUNT_RST;
    logic               cfg_doubling = 1'b0;

    decay_result_t pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int words_fed = 0;
    int results_checked = 0;
    int settings_applied = 0;
    longint quiet_cycles = 0;

    rk4_exponential_decay_integrator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------

    // signed value from sign and magnitude, saturated to the data width
    function automatic fx_t clamp_mag(input bit neg, input logic [63:0] mag);
        if (neg) begin
            if (mag > MAG_TOP) return fx_t'(FX_LO);
            return fx_t'(-longint'(mag));
        end
        if (mag > 64'(FX_HI)) return fx_t'(FX_HI);
        return fx_t'(mag);
    endfunction

    function automatic fx_t add_sat(input fx_t a, input fx_t b);
        longint sum;
        sum = longint'(a) + longint'(b);
        if (sum > FX_HI) return fx_t'(FX_HI);
        if (sum < FX_LO) return fx_t'(FX_LO);
        return fx_t'(sum);
    endfunction

    // negating the most negative value saturates to the most positive one
    function automatic fx_t neg_sat(input fx_t a);
        if (longint'(a) == FX_LO) return fx_t'(FX_HI);
        return fx_t'(-longint'(a));
    endfunction

    // exact product, rounded half away from zero, then scaled back
    function automatic fx_t mul_coef(input fx_t k, input logic [63:0] c);
        bit          neg;
        logic [63:0] a;
        logic [63:0] prod;
        neg = k < 0;
        a = neg ? 64'(-longint'(k)) : 64'(longint'(k));
        prod = a * c;
        return clamp_mag(neg, (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    endfunction

    function automatic rk_coef_t coef_for(input logic [63:0] s);
        rk_coef_t c;
        c.c6 = (s + 3) / 6;
        c.c3 = (s + 1) / 3;
        c.c2 = (s + 1) / 2;
        c.c1 = s;
        return c;
    endfunction

    // one classic rk4 step of y' = -y
    function automatic fx_t classic_step(input fx_t y0, input rk_coef_t c);
        fx_t k;
        fx_t y;
        fx_t t;
        k = neg_sat(y0);
        y = add_sat(y0, mul_coef(k, c.c6));
        t = add_sat(y0, mul_coef(k, c.c2));
        k = neg_sat(t);
        y = add_sat(y, mul_coef(k, c.c3));
        t = add_sat(y0, mul_coef(k, c.c2));
        k = neg_sat(t);
        y = add_sat(y, mul_coef(k, c.c3));
        t = add_sat(y0, mul_coef(k, c.c1));
        k = neg_sat(t);
        return add_sat(y, mul_coef(k, c.c6));
    endfunction

    // 4*(half - full)/15 with the difference taken exactly
    function automatic fx_t doubling_error(input fx_t half_y, input fx_t full_y);
        bit          neg;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        neg = half_y < full_y;
        d = neg ? 64'(longint'(full_y) - longint'(half_y))
                : 64'(longint'(half_y) - longint'(full_y));
        q = d / 15;
        r = d % 15;
        return clamp_mag(neg, 4 * q + (8 * r + 15) / 30);
    endfunction

    function automatic decay_result_t integrate(input fx_t y0, input logic last);
        rk_coef_t      full_c;
        rk_coef_t      half_c;
        fx_t           y;
        fx_t           y_full;
        decay_result_t res;
        full_c = coef_for(64'(cfg_step));
        half_c = coef_for((64'(cfg_step) + 1) >> 1);
        y = y0;
        res.error_estimate = '0;
        for (int n = 0; n < int'(cfg_count); n++) begin
            if (cfg_doubling) begin
                y_full = classic_step(y, full_c);
                y = classic_step(classic_step(y, half_c), half_c);
                res.error_estimate = doubling_error(y, y_full);
            end else begin
                y = classic_step(y, full_c);
            end
        end
        res.final_value = y;
        res.batch_end = last;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // receiver stalls at random; inputs change on the falling edge only
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // send one input word; called and returns on a falling edge
    task automatic feed_value(input fx_t value, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(value);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        // word taken at this edge: the expectation uses the settings now in force
        pending_results.push_back(integrate(value, last));
        words_fed++;
        @(negedge aclk);
    endtask

    // stop sending and let every expected word come back, then a short pause
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(negedge aclk);
    endtask

    // write all three registers while the block is idle
    task automatic apply_config(input logic [CFG_DW-1:0] step_word,
                                input logic [CFG_DW-1:0] count_word,
                                input logic [CFG_DW-1:0] mode_word);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_STEP_SIZE;
        cfg_wdata <= step_word;
        @(negedge aclk);
        cfg_index <= REG_STEP_COUNT;
        cfg_wdata <= count_word;
        @(negedge aclk);
        cfg_index <= REG_DOUBLING;
        cfg_wdata <= mode_word;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_step = step_word[STEP_W-1:0];
        cfg_count = count_word[COUNT_W-1:0];
        cfg_doubling = mode_word[0];
        settings_applied++;
    endtask

    function automatic fx_t random_value();
        case ($urandom_range(0, 4))
            0, 1:    return fx_t'($urandom);
            2:       return fx_t'(longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29));
            3:       return fx_t'(FX_HI - longint'($urandom_range(0, 255)));
            default: return fx_t'(FX_LO + longint'($urandom_range(0, 255)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic check_field(input string field, input logic [DATA_WIDTH-1:0] want,
                               input logic [DATA_WIDTH-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endtask

    // result words are sampled on the rising edge
    always @(posedge aclk) begin
        decay_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word, expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = pending_results.pop_front();
                check_field("final_value", want.final_value, m_tdata[DATA_WIDTH-1:0]);
                check_field("error_estimate", want.error_estimate,
                            m_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                check_field("batch_end_out", DATA_WIDTH'(want.batch_end),
                            DATA_WIDTH'(m_tlast));
                results_checked++;
            end
        end
    end

    // watchdog: cycles without any word or register write, limit scaled by the
    // slowest item under the current settings (an item in doubling mode)
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 4 * (33 * longint'(cfg_count) + 10) + 2000) begin
            $display("%0t: timeout, %0d result words still expected",
                     $time, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings (h = 0.01, 100 plain steps) with the value extremes
    task automatic test_reset_defaults();
        feed_value(fx_t'(0), 1'b0);
        feed_value(fx_t'(1), 1'b1);
        feed_value(fx_t'(-1), 1'b0);
        feed_value(fx_t'(FX_HI), 1'b0);
        feed_value(fx_t'(FX_LO), 1'b1);
        feed_value(fx_t'(ONE_FX), 1'b0);
        feed_value(fx_t'(-longint'(ONE_FX)), 1'b1);
        feed_value(fx_t'(32'h5555_5555), 1'b1);
    endtask

    // step size extremes, step size above 1.0, doubling mode and zero step count
    task automatic test_step_extremes();
        apply_config(CFG_DW'(ONE_FX), CFG_DW'(3), CFG_DW'(1));
        feed_value(fx_t'(FX_HI), 1'b0);
        feed_value(fx_t'(FX_LO), 1'b1);
        feed_value(fx_t'(-longint'(ONE_FX)), 1'b0);
        apply_config(CFG_DW'(0), CFG_DW'(2), CFG_DW'(1));
        feed_value(fx_t'(ONE_FX), 1'b1);
        feed_value(fx_t'(-1), 1'b0);
        // above 1.0 the products can saturate
        apply_config(CFG_DW'(STEP_TOP), CFG_DW'(2), CFG_DW'(0));
        feed_value(fx_t'(FX_HI), 1'b1);
        feed_value(fx_t'(12345678), 1'b0);
        apply_config(CFG_DW'(STEP_TOP), CFG_DW'(1), CFG_DW'(1));
        feed_value(fx_t'(FX_LO), 1'b1);
        // zero steps: value passes unchanged, no error estimate
        apply_config(CFG_DW'(STEP_SIZE_RST), CFG_DW'(0), CFG_DW'(1));
        feed_value(fx_t'(32'h1234_5678), 1'b0);
        feed_value(fx_t'(FX_LO), 1'b1);
    endtask

    // largest step count, plain mode, a single value
    task automatic test_long_run();
        apply_config(CFG_DW'($urandom_range(1, 1 << 26)), CFG_DW'(16'hffff), CFG_DW'(0));
        feed_value(random_value(), 1'b1);
    endtask

    // random settings and values under one idling pattern; step counts stay
    // small so the run stays short, junk above the count and mode fields is ignored
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        logic [CFG_DW-1:0] step_word;
        logic [CFG_DW-1:0] count_word;
        int                pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int set = 0; set < 6; set++) begin
            case ($urandom_range(0, 3))
                0: step_word = CFG_DW'($urandom_range(0, 1 << 28));
                1: step_word = CFG_DW'($urandom_range(0, 1 << 22));
                2: begin
                    pick = $urandom_range(0, 2);
                    step_word = (pick == 0) ? CFG_DW'(0)
                              : (pick == 1) ? CFG_DW'(ONE_FX) : CFG_DW'(STEP_TOP);
                end
                default: step_word = CFG_DW'($urandom);
            endcase
            count_word = CFG_DW'($urandom);
            pick = $urandom_range(0, 9);
            count_word[COUNT_W-1:0] = (pick == 0) ? COUNT_W'(0)
                                    : (pick < 8) ? COUNT_W'($urandom_range(1, 6))
                                    : COUNT_W'($urandom_range(7, 40));
            apply_config(step_word, count_word, CFG_DW'($urandom));
            for (int n = 0; n < 30; n++)
                feed_value(random_value(), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_step_extremes();
        test_long_run();
        test_random_traffic(0, 0);
        test_random_traffic(63, 0);
        test_random_traffic(0, 63);
        test_random_traffic(10, 10);

        // let any stray word show up before the verdict
        wait_drained();
        repeat (64) @(posedge aclk);

        $display("covered %0d input words and %0d result words over %0d register settings",
                 words_fed, results_checked, settings_applied);
        $display("plain and step-doubling modes, zero and maximum step counts, four idling patterns");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### rk4_exponential_decay_integrator.f
rtl/rk4ed_pkg.sv
rtl/rk4ed_mul.sv
rtl/rk4ed_core.sv
rtl/rk4_exponential_decay_integrator.sv
rtl/rk4ed_chk.sv
tb/tb.sv
